// File: design/obm_pkg.sv
package obm_pkg;

  // instruction codes, the two top codes are illegal
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_HALT      = 4'd1,
    OP_PTR_DOWN  = 4'd2,
    OP_PTR_UP    = 4'd3,
    OP_ACC_CLR   = 4'd4,
    OP_ACC_SET   = 4'd5,
    OP_ACC_NOT   = 4'd6,
    OP_ACC_IN    = 4'd7,
    OP_MEM_AND   = 4'd8,
    OP_MEM_STORE = 4'd9,
    OP_PUSH      = 4'd10,
    OP_POP_AND   = 4'd11,
    OP_LATCH     = 4'd12,
    OP_OUT       = 4'd13
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HALTED    = 3'd1,
    ST_PTR_UNDER = 3'd2,
    ST_PTR_OVER  = 3'd3,
    ST_STK_OVER  = 3'd4,
    ST_STK_UNDER = 3'd5,
    ST_BAD_OP    = 3'd6,
    ST_STOPPED   = 3'd7
  } status_e;

  localparam int unsigned STEP_W     = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CBITS_W    = 3;
  localparam logic [CBITS_W-1:0] CBITS_LAST = 3'd7;
  localparam logic [STEP_W-1:0]  STEP_MAX   = 32'hFFFF_FFFF;

  // apb register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_CHAR_MODE = 1'b0;

  // machine state as seen by the execute logic
  typedef struct packed {
    logic               stopped;
    logic               acc;
    logic               latch;
    logic               char_mode;
    logic [CHAR_W-1:0]  char_shift;
    logic [CBITS_W-1:0] char_bits;
    logic               ptr_at_min;
    logic               ptr_at_max;
    logic               ptr_at_fill;
    logic               mem_bit;
    logic               stk_empty;
    logic               stk_full;
    logic               stk_top;
  } view_t;

  // next values and update strobes from the execute logic
  typedef struct packed {
    status_e            status;
    logic               stop;
    logic               count;
    logic               acc_d;
    logic               latch_d;
    logic [CHAR_W-1:0]  char_shift_d;
    logic [CBITS_W-1:0] char_bits_d;
    logic               ptr_down;
    logic               ptr_up;
    logic               mem_we;
    logic               mem_wdata;
    logic               push;
    logic               pop;
    logic               out_valid;
    logic               out_is_char;
    logic [CHAR_W-1:0]  out_value;
  } ctrl_t;

endpackage

// File: design/obm_ram.sv
module obm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/obm_exec.sv
module obm_exec (
  input  obm_pkg::opcode_e op_i,
  input  logic             in_bit_i,
  input  obm_pkg::view_t   view_i,
  output obm_pkg::ctrl_t   ctrl_o
);

  obm_pkg::status_e   status;
  logic               acc_d;
  logic               latch_d;
  logic [7:0]         shift_d;
  logic [2:0]         cbits_d;
  logic               ptr_down;
  logic               ptr_up;
  logic               mem_we;
  logic               mem_wdata;
  logic               push;
  logic               pop;
  logic               out_valid;
  logic               out_is_char;
  logic [7:0]         out_value;

  always_comb begin
    status      = obm_pkg::ST_OK;
    acc_d       = view_i.acc;
    latch_d     = view_i.latch;
    shift_d     = view_i.char_shift;
    cbits_d     = view_i.char_bits;
    ptr_down    = 1'b0;
    ptr_up      = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    out_valid   = 1'b0;
    out_is_char = 1'b0;
    out_value   = '0;
    if (view_i.stopped) begin
      status = obm_pkg::ST_STOPPED;
    end else begin
      case (op_i)
        obm_pkg::OP_NOP: begin
        end
        obm_pkg::OP_HALT: begin
          if (view_i.acc) status = obm_pkg::ST_HALTED;
        end
        obm_pkg::OP_PTR_DOWN: begin
          if (view_i.ptr_at_min) status = obm_pkg::ST_PTR_UNDER;
          else ptr_down = 1'b1;
        end
        obm_pkg::OP_PTR_UP: begin
          if (view_i.ptr_at_max) begin
            status = obm_pkg::ST_PTR_OVER;
          end else begin
            ptr_up = 1'b1;
            // first step past the filled region zeroes the cell left behind
            mem_we = view_i.ptr_at_fill;
          end
        end
        obm_pkg::OP_ACC_CLR: acc_d = 1'b0;
        obm_pkg::OP_ACC_SET: acc_d = 1'b1;
        obm_pkg::OP_ACC_NOT: acc_d = ~view_i.acc;
        obm_pkg::OP_ACC_IN: begin
          if (view_i.acc) acc_d = in_bit_i;
        end
        obm_pkg::OP_MEM_AND: acc_d = view_i.acc & view_i.mem_bit;
        obm_pkg::OP_MEM_STORE: begin
          mem_we    = 1'b1;
          mem_wdata = view_i.acc;
        end
        obm_pkg::OP_PUSH: begin
          if (view_i.stk_full) status = obm_pkg::ST_STK_OVER;
          else push = 1'b1;
        end
        obm_pkg::OP_POP_AND: begin
          if (view_i.stk_empty) begin
            status = obm_pkg::ST_STK_UNDER;
          end else begin
            pop   = 1'b1;
            acc_d = view_i.acc & view_i.stk_top;
          end
        end
        obm_pkg::OP_LATCH: latch_d = view_i.acc;
        obm_pkg::OP_OUT: begin
          if (view_i.acc) begin
            if (!view_i.char_mode) begin
              out_valid = 1'b1;
              out_value = {7'b0, view_i.latch};
            end else begin
              shift_d = {view_i.char_shift[6:0], view_i.latch};
              if (view_i.char_bits != obm_pkg::CBITS_LAST) begin
                cbits_d = view_i.char_bits + 3'd1;
              end else begin
                cbits_d     = '0;
                out_valid   = 1'b1;
                out_is_char = 1'b1;
                out_value   = shift_d;
              end
            end
          end
        end
        default: status = obm_pkg::ST_BAD_OP;
      endcase
    end
  end

  always_comb begin
    ctrl_o.status       = status;
    ctrl_o.stop         = (status != obm_pkg::ST_OK) && !view_i.stopped;
    ctrl_o.count        = !view_i.stopped;
    ctrl_o.acc_d        = acc_d;
    ctrl_o.latch_d      = latch_d;
    ctrl_o.char_shift_d = shift_d;
    ctrl_o.char_bits_d  = cbits_d;
    ctrl_o.ptr_down     = ptr_down;
    ctrl_o.ptr_up       = ptr_up;
    ctrl_o.mem_we       = mem_we;
    ctrl_o.mem_wdata    = mem_wdata;
    ctrl_o.push         = push;
    ctrl_o.pop          = pop;
    ctrl_o.out_valid    = out_valid;
    ctrl_o.out_is_char  = out_is_char;
    ctrl_o.out_value    = out_value;
  end

endmodule

// File: design/one_bit_machine_executor_top.sv
// one-bit machine executor
// input channel: in_valid_i / in_stall_o carry one instruction per transfer
//   (opcode_i, in_bit_i); a transfer happens when valid is high and stall low
// result channel: res_valid_o / res_stall_i carry one result per instruction
//   (status, step index and the optional output bit or character)
// each instruction passes the input register, then the execute stage that
//   updates the machine and loads the result register
// throughput: one instruction per cycle when not stalled, set by the single
//   execute stage; each instruction reads one memory bit and one stack bit,
//   prefetched from registered-read rams at the address the state will hold
// when the receiver stalls, the result register holds and the input register
//   fills; once both are full in_stall_o rises, nothing is lost
// reset clears all control state; bit memory cells become zero through a
//   fill mark (cells above it read as zero), so no clearing pass is needed
// after halt or a fault every instruction returns the stopped status until
//   the next reset; char_mode is to be written over the apb port only while
//   the block is idle, which the block itself does not enforce
module one_bit_machine_executor_top #(
  parameter int unsigned MEM_BITS    = 1024,
  parameter int unsigned STACK_LIMIT = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // instruction channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [3:0]                      opcode_i,
  input  logic                            in_bit_i,
  // result channel
  output logic                            res_valid_o,
  input  logic                            res_stall_i,
  output logic [2:0]                      status_o,
  output logic [obm_pkg::STEP_W-1:0]      step_index_o,
  output logic                            out_valid_o,
  output logic                            out_is_char_o,
  output logic [obm_pkg::CHAR_W-1:0]      out_value_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [obm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [obm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [obm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned PTR_W  = $clog2(MEM_BITS);
  localparam int unsigned FILL_W = $clog2(MEM_BITS + 1);
  localparam int unsigned CNT_W  = $clog2(STACK_LIMIT + 1);
  localparam int unsigned SIDX_W = (STACK_LIMIT > 1) ? $clog2(STACK_LIMIT) : 1;

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic char_mode_q;
  logic cfg_sel_char;

  assign pready       = 1'b1;
  assign cfg_sel_char = (paddr[obm_pkg::CFG_ADDR_W-1] == obm_pkg::REG_CHAR_MODE);
  assign prdata       = cfg_sel_char ? {{(obm_pkg::CFG_DATA_W-1){1'b0}}, char_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_sel_char) begin
      char_mode_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------
  // input register and handshake
  // ---------------------------------------------------------------------
  logic             s1_valid_q;
  obm_pkg::opcode_e s1_op_q;
  logic             s1_bit_q;
  logic             in_xfer;
  logic             exec_fire;
  logic             res_valid_q;

  // execute when an instruction waits and the result register can take it
  assign exec_fire  = s1_valid_q && (!res_valid_q || !res_stall_i);
  assign in_stall_o = s1_valid_q && !exec_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer || (s1_valid_q && !exec_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q  <= obm_pkg::opcode_e'(opcode_i);
      s1_bit_q <= in_bit_i;
    end
  end

  // ---------------------------------------------------------------------
  // machine state
  // ---------------------------------------------------------------------
  logic                        acc_q;
  logic                        latch_q;
  logic [PTR_W-1:0]            ptr_q, ptr_d;
  logic [FILL_W-1:0]           fill_q, fill_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [obm_pkg::CHAR_W-1:0]  char_shift_q;
  logic [obm_pkg::CBITS_W-1:0] char_bits_q;
  logic [obm_pkg::STEP_W-1:0]  step_q;
  logic                        stopped_q;

  obm_pkg::view_t view;
  obm_pkg::ctrl_t ctrl;

  // memory and stack read paths with same-address write bypass
  logic             mem_rdata;
  logic             mem_byp_q, mem_byp_bit_q;
  logic             mem_we;
  logic             stk_rdata;
  logic             stk_byp_q, stk_byp_bit_q;
  logic             stk_we;
  logic [SIDX_W-1:0] stk_waddr, stk_raddr;
  logic [CNT_W-1:0]  cnt_top;
  logic              ptr_at_fill;

  assign ptr_at_fill = (FILL_W'(ptr_q) == fill_q);

  always_comb begin
    view.stopped     = stopped_q;
    view.acc         = acc_q;
    view.latch       = latch_q;
    view.char_mode   = char_mode_q;
    view.char_shift  = char_shift_q;
    view.char_bits   = char_bits_q;
    view.ptr_at_min  = (ptr_q == '0);
    view.ptr_at_max  = (ptr_q == PTR_W'(MEM_BITS - 1));
    view.ptr_at_fill = ptr_at_fill;
    // cells at or above the fill mark were never written since reset
    view.mem_bit     = (FILL_W'(ptr_q) < fill_q) && (mem_byp_q ? mem_byp_bit_q : mem_rdata);
    view.stk_empty   = (cnt_q == '0);
    view.stk_full    = (cnt_q == CNT_W'(STACK_LIMIT));
    view.stk_top     = stk_byp_q ? stk_byp_bit_q : stk_rdata;
  end

  obm_exec u_exec (
    .op_i     (s1_op_q),
    .in_bit_i (s1_bit_q),
    .view_i   (view),
    .ctrl_o   (ctrl)
  );

  // next pointer, fill mark and stack depth
  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    if (exec_fire) begin
      if (ctrl.ptr_down) ptr_d = ptr_q - PTR_W'(1);
      if (ctrl.ptr_up)   ptr_d = ptr_q + PTR_W'(1);
      if (ctrl.mem_we && ptr_at_fill) fill_d = fill_q + FILL_W'(1);
      if (ctrl.push) cnt_d = cnt_q + CNT_W'(1);
      if (ctrl.pop)  cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign mem_we    = exec_fire && ctrl.mem_we;
  assign stk_we    = exec_fire && ctrl.push;
  assign stk_waddr = cnt_q[SIDX_W-1:0];
  assign cnt_top   = cnt_d - CNT_W'(1);
  assign stk_raddr = (cnt_d == '0) ? '0 : cnt_top[SIDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= 1'b0;
      latch_q      <= 1'b0;
      ptr_q        <= '0;
      fill_q       <= '0;
      cnt_q        <= '0;
      char_shift_q <= '0;
      char_bits_q  <= '0;
      step_q       <= '0;
      stopped_q    <= 1'b0;
      mem_byp_q    <= 1'b0;
      stk_byp_q    <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      mem_byp_q <= mem_we && (ptr_d == ptr_q);
      stk_byp_q <= stk_we && (stk_raddr == stk_waddr);
      if (exec_fire) begin
        acc_q        <= ctrl.acc_d;
        latch_q      <= ctrl.latch_d;
        char_shift_q <= ctrl.char_shift_d;
        char_bits_q  <= ctrl.char_bits_d;
        if (ctrl.stop) stopped_q <= 1'b1;
        // saturating instruction count
        if (ctrl.count && (step_q != obm_pkg::STEP_MAX)) step_q <= step_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mem_byp_bit_q <= ctrl.mem_wdata;
    stk_byp_bit_q <= acc_q;
  end

  obm_ram #(
    .WIDTH (1),
    .DEPTH (MEM_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ptr_q),
    .wdata_i (ctrl.mem_wdata),
    .raddr_i (ptr_d),
    .rdata_o (mem_rdata)
  );

  obm_ram #(
    .WIDTH (1),
    .DEPTH (STACK_LIMIT)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (acc_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  obm_pkg::status_e            res_status_q;
  logic [obm_pkg::STEP_W-1:0]  res_step_q;
  logic                        res_out_valid_q;
  logic                        res_out_char_q;
  logic [obm_pkg::CHAR_W-1:0]  res_out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= exec_fire || (res_valid_q && res_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_status_q    <= ctrl.status;
      res_step_q      <= step_q;
      res_out_valid_q <= ctrl.out_valid;
      res_out_char_q  <= ctrl.out_is_char;
      res_out_value_q <= ctrl.out_value;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign step_index_o  = res_step_q;
  assign out_valid_o   = res_out_valid_q;
  assign out_is_char_o = res_out_char_q;
  assign out_value_o   = res_out_value_q;

endmodule

// File: tb/tb_one_bit_machine_executor_top.sv
module tb_one_bit_machine_executor_top;

  localparam int unsigned MEM_BITS    = 1024;
  localparam int unsigned STACK_LIMIT = 15;
  localparam logic [9:0]  PTR_MAX     = 10'(MEM_BITS - 1);
  localparam logic [3:0]  DEPTH_MAX   = 4'(STACK_LIMIT);
  localparam logic [obm_pkg::CFG_ADDR_W-1:0] CHAR_MODE_ADDR =
    obm_pkg::CFG_ADDR_W'(4 * obm_pkg::REG_CHAR_MODE);
  localparam int unsigned SEG_ITEMS     = 390;  // random instructions per phase
  localparam int unsigned AFTER_STOP    = 20;   // instructions fed to the stopped block
  localparam int unsigned DRAIN_CYCLES  = 8;    // settling margin after the last expected result
  localparam int unsigned STALL_LIMIT   = 2000; // cycles without any transfer
  localparam int unsigned NUM_DIRECTED  = 25;

  // one result as the block reports it
  typedef struct packed {
    obm_pkg::status_e            status;
    logic [obm_pkg::STEP_W-1:0]  step;
    logic                        ov;
    logic                        oc;
    logic [obm_pkg::CHAR_W-1:0]  val;
  } outcome_t;

  // directed row: fixed rows carry their expected result, others use the predictor
  typedef struct {
    obm_pkg::opcode_e op;
    logic             b;
    bit               fixed;
    outcome_t         want;
  } directed_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [3:0]                      opcode_i;
  logic                            in_bit_i;
  logic                            res_valid_o;
  logic                            res_stall_i;
  logic [2:0]                      status_o;
  logic [obm_pkg::STEP_W-1:0]      step_index_o;
  logic                            out_valid_o;
  logic                            out_is_char_o;
  logic [obm_pkg::CHAR_W-1:0]      out_value_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [obm_pkg::CFG_ADDR_W-1:0]  paddr;
  logic [obm_pkg::CFG_DATA_W-1:0]  pwdata;
  logic [obm_pkg::CFG_DATA_W-1:0]  prdata;
  logic                            pready;

  one_bit_machine_executor_top #(
    .MEM_BITS   (MEM_BITS),
    .STACK_LIMIT(STACK_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .in_bit_i     (in_bit_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .status_o     (status_o),
    .step_index_o (step_index_o),
    .out_valid_o  (out_valid_o),
    .out_is_char_o(out_is_char_o),
    .out_value_o  (out_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // mirror of the machine, advanced once per accepted instruction
  bit              m_char_mode;
  bit              m_acc;
  bit              m_latch;
  bit              m_mem [MEM_BITS];
  logic [9:0]      m_ptr;
  bit              m_stack [STACK_LIMIT];
  logic [3:0]      m_depth;
  logic [obm_pkg::CHAR_W-1:0]  m_shift;
  logic [obm_pkg::CBITS_W-1:0] m_nbits;
  logic [obm_pkg::STEP_W-1:0]  m_steps;
  bit              m_stopped;

  outcome_t        pending_results [$];
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  int unsigned     mismatches;
  int unsigned     instr_count;
  int unsigned     bits_seen;
  int unsigned     chars_seen;
  int unsigned     idle_cycles;

  // directed opening: extremes, every legal operation, output with and without acc
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{obm_pkg::OP_NOP,       1'b0, 1'b1, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    // acc clear: no halt
    '{obm_pkg::OP_HALT,      1'b1, 1'b1, '{obm_pkg::ST_OK, 32'd1, 1'b0, 1'b0, 8'd0}},
    // acc clear: no output
    '{obm_pkg::OP_OUT,       1'b0, 1'b1, '{obm_pkg::ST_OK, 32'd2, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_SET,   1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    // latch still zero
    '{obm_pkg::OP_OUT,       1'b1, 1'b1, '{obm_pkg::ST_OK, 32'd4, 1'b1, 1'b0, 8'd0}},
    '{obm_pkg::OP_LATCH,     1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_OUT,       1'b0, 1'b1, '{obm_pkg::ST_OK, 32'd6, 1'b1, 1'b0, 8'd1}},
    '{obm_pkg::OP_ACC_IN,    1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_IN,    1'b1, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_NOT,   1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_IN,    1'b1, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_MEM_STORE, 1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_PTR_UP,    1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_MEM_AND,   1'b1, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_PTR_DOWN,  1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_SET,   1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_MEM_AND,   1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_PUSH,      1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_CLR,   1'b1, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_PUSH,      1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_SET,   1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    // pops a zero
    '{obm_pkg::OP_POP_AND,   1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_ACC_SET,   1'b1, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    // pops a one
    '{obm_pkg::OP_POP_AND,   1'b0, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}},
    '{obm_pkg::OP_OUT,       1'b1, 1'b0, '{obm_pkg::ST_OK, 32'd0, 1'b0, 1'b0, 8'd0}}
  };

  // clock, period 8
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // execute one instruction on the mirror and return what the block must report
  function automatic outcome_t run_instruction(logic [3:0] op, logic b);
    outcome_t r;
    r        = '0;
    r.status = obm_pkg::ST_OK;
    r.step   = m_steps;
    // a stopped machine only reports, nothing moves
    if (m_stopped) begin
      r.status = obm_pkg::ST_STOPPED;
      return r;
    end
    case (op)
      obm_pkg::OP_NOP:       ;
      obm_pkg::OP_HALT:      if (m_acc) r.status = obm_pkg::ST_HALTED;
      obm_pkg::OP_PTR_DOWN: begin
        if (m_ptr != '0) m_ptr = m_ptr - 10'd1;
        else r.status = obm_pkg::ST_PTR_UNDER;
      end
      obm_pkg::OP_PTR_UP: begin
        if (m_ptr != PTR_MAX) m_ptr = m_ptr + 10'd1;
        else r.status = obm_pkg::ST_PTR_OVER;
      end
      obm_pkg::OP_ACC_CLR:   m_acc = 1'b0;
      obm_pkg::OP_ACC_SET:   m_acc = 1'b1;
      obm_pkg::OP_ACC_NOT:   m_acc = !m_acc;
      obm_pkg::OP_ACC_IN:    if (m_acc) m_acc = b;
      obm_pkg::OP_MEM_AND:   m_acc = m_acc & m_mem[m_ptr];
      obm_pkg::OP_MEM_STORE: m_mem[m_ptr] = m_acc;
      obm_pkg::OP_PUSH: begin
        if (m_depth < DEPTH_MAX) begin
          m_stack[m_depth] = m_acc;
          m_depth = m_depth + 4'd1;
        end else begin
          r.status = obm_pkg::ST_STK_OVER;
        end
      end
      obm_pkg::OP_POP_AND: begin
        if (m_depth != '0) begin
          m_depth = m_depth - 4'd1;
          m_acc   = m_acc & m_stack[m_depth];
        end else begin
          r.status = obm_pkg::ST_STK_UNDER;
        end
      end
      obm_pkg::OP_LATCH:     m_latch = m_acc;
      obm_pkg::OP_OUT: begin
        if (m_acc) begin
          if (!m_char_mode) begin
            r.ov  = 1'b1;
            r.val = obm_pkg::CHAR_W'(m_latch);
          end else begin
            // shift the bit in, emit only when the eighth bit completes a character
            m_shift = {m_shift[obm_pkg::CHAR_W-2:0], m_latch};
            if (m_nbits != obm_pkg::CBITS_LAST) begin
              m_nbits = m_nbits + 3'd1;
            end else begin
              m_nbits = '0;
              r.ov    = 1'b1;
              r.oc    = 1'b1;
              r.val   = m_shift;
            end
          end
        end
      end
      default:      r.status = obm_pkg::ST_BAD_OP;
    endcase
    if (r.status != obm_pkg::ST_OK) m_stopped = 1'b1;
    if (m_steps != obm_pkg::STEP_MAX) m_steps = m_steps + 32'd1;
    return r;
  endfunction

  // random legal instruction that keeps the machine running, biased toward output
  function automatic logic [3:0] pick_running_op();
    int unsigned      r;
    obm_pkg::opcode_e op;
    r = $urandom_range(0, 99);
    if (r < 30)      op = obm_pkg::OP_OUT;
    else if (r < 40) op = obm_pkg::OP_LATCH;
    else if (r < 50) op = obm_pkg::OP_ACC_SET;
    else             op = obm_pkg::opcode_e'($urandom_range(0, 13));
    if (op == obm_pkg::OP_HALT && m_acc)            op = obm_pkg::OP_ACC_CLR;
    if (op == obm_pkg::OP_PTR_DOWN && m_ptr == '0)  op = obm_pkg::OP_PTR_UP;
    if (op == obm_pkg::OP_PTR_UP && m_ptr == PTR_MAX) op = obm_pkg::OP_PTR_DOWN;
    if (op == obm_pkg::OP_PUSH && m_depth == DEPTH_MAX) op = obm_pkg::OP_POP_AND;
    if (op == obm_pkg::OP_POP_AND && m_depth == '0) op = obm_pkg::OP_PUSH;
    return op;
  endfunction

  // present one instruction, wait for its transfer, then record the expected result
  task automatic send_instr(logic [3:0] op, logic b, bit fixed = 1'b0,
                            outcome_t want = '0);
    outcome_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    in_bit_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    predicted = run_instruction(op, b);
    pending_results.push_back(fixed ? want : predicted);
    instr_count++;
  endtask

  // wait until every result is back, plus the pipeline latency
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one apb transfer: setup cycle, then access cycle until pready
  task automatic apb_access(logic wr, logic [obm_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [obm_pkg::CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CHAR_MODE_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write char_mode, read it back, and switch the mirror over
  task automatic set_char_mode(bit mode);
    logic [obm_pkg::CFG_DATA_W-1:0] rd;
    apb_access(1'b1, obm_pkg::CFG_DATA_W'(mode), rd);
    @(posedge clk_i);
    apb_access(1'b0, '0, rd);
    if (rd !== obm_pkg::CFG_DATA_W'(mode)) begin
      $error("char_mode readback: expected %0d, got %0h", mode, rd);
      mismatches++;
    end
    m_char_mode = mode;
  endtask

  // drive the machine into the chosen stop, counting on the mirror for the distance
  task automatic drive_stop(obm_pkg::status_e cause);
    case (cause)
      obm_pkg::ST_HALTED: begin
        send_instr(obm_pkg::OP_ACC_SET, 1'b0);
        send_instr(obm_pkg::OP_HALT, 1'($urandom_range(0, 1)));
      end
      obm_pkg::ST_PTR_UNDER: begin
        while (m_ptr != '0) send_instr(obm_pkg::OP_PTR_DOWN, 1'($urandom_range(0, 1)));
        send_instr(obm_pkg::OP_PTR_DOWN, 1'($urandom_range(0, 1)));
      end
      obm_pkg::ST_PTR_OVER: begin
        while (m_ptr != PTR_MAX) send_instr(obm_pkg::OP_PTR_UP, 1'($urandom_range(0, 1)));
        send_instr(obm_pkg::OP_PTR_UP, 1'($urandom_range(0, 1)));
      end
      obm_pkg::ST_STK_OVER: begin
        while (m_depth != DEPTH_MAX) send_instr(obm_pkg::OP_PUSH, 1'($urandom_range(0, 1)));
        send_instr(obm_pkg::OP_PUSH, 1'($urandom_range(0, 1)));
      end
      obm_pkg::ST_STK_UNDER: begin
        while (m_depth != '0) send_instr(obm_pkg::OP_POP_AND, 1'($urandom_range(0, 1)));
        send_instr(obm_pkg::OP_POP_AND, 1'($urandom_range(0, 1)));
      end
      default: begin
        // illegal opcode, either of the two top codes
        send_instr(4'($urandom_range(14, 15)), 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // receiver: random stall at the configured rate
  always @(posedge clk_i) begin
    res_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // result checker: each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d step %0d",
               status_o, step_index_o);
        mismatches++;
      end else begin
        automatic outcome_t exp = pending_results.pop_front();
        if (status_o !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status_o);
          mismatches++;
        end
        if (step_index_o !== exp.step) begin
          $error("step_index: expected %0d, got %0d", exp.step, step_index_o);
          mismatches++;
        end
        if (out_valid_o !== exp.ov) begin
          $error("out_valid: expected %0d, got %0d", exp.ov, out_valid_o);
          mismatches++;
        end
        if (out_is_char_o !== exp.oc) begin
          $error("out_is_char: expected %0d, got %0d", exp.oc, out_is_char_o);
          mismatches++;
        end
        if (out_value_o !== exp.val) begin
          $error("out_value: expected %0h, got %0h", exp.val, out_value_o);
          mismatches++;
        end
        if (exp.ov && exp.oc) chars_seen++;
        else if (exp.ov)      bits_seen++;
      end
    end
  end

  // watchdog: too long without any transfer on either channel means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[one_bit_machine_executor_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned      seg;
    obm_pkg::status_e cause;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = '0;
    in_bit_i      = 1'b0;
    res_stall_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    mismatches    = 0;
    instr_count   = 0;
    bits_seen     = 0;
    chars_seen    = 0;
    idle_cycles   = 0;
    m_char_mode   = 1'b0;
    m_acc         = 1'b0;
    m_latch       = 1'b0;
    m_ptr         = '0;
    m_depth       = '0;
    m_shift       = '0;
    m_nbits       = '0;
    m_steps       = '0;
    m_stopped     = 1'b0;
    cause         = obm_pkg::status_e'($urandom_range(obm_pkg::ST_HALTED,
                                                      obm_pkg::ST_BAD_OP));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // four phases: char_mode 0,1,0,1; idling receiver-heavy, sender-heavy, then none
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          send_idle_pct = 27;
          stall_pct     = 61;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct     = 27;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      set_char_mode(seg[0]);

      if (seg == 0) begin
        foreach (directed_rows[i])
          send_instr(directed_rows[i].op, directed_rows[i].b,
                     directed_rows[i].fixed, directed_rows[i].want);
      end

      repeat (SEG_ITEMS) send_instr(pick_running_op(), 1'($urandom_range(0, 1)));

      // last phase: stop the machine, then check that it stays stopped
      if (seg == 3) begin
        drive_stop(cause);
        repeat (AFTER_STOP)
          send_instr(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end

      in_valid_i <= 1'b0;
      wait_drained();
    end

    $display("covered %0d instructions in both output modes, %0d bits and %0d characters out",
             instr_count, bits_seen, chars_seen);
    $display("machine stopped by %s after %0d steps", cause.name(), m_steps);
    if (mismatches == 0) begin
      $display("[one_bit_machine_executor_top] OK");
    end else begin
      $display("[one_bit_machine_executor_top] ERROR");
    end
    $finish;
  end

endmodule

// File: one_bit_machine_executor_top.f
design/obm_pkg.sv
design/obm_ram.sv
design/obm_exec.sv
design/one_bit_machine_executor_top.sv
tb/tb_one_bit_machine_executor_top.sv
